FILE: rtl/core/scrolling_text_window_assert.svh
`ifndef SCROLLING_TEXT_WINDOW_ASSERT_SVH
`define SCROLLING_TEXT_WINDOW_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define STW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scrolling_text_window check failed");

// next-cycle implication, checked on clk outside reset
`define STW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scrolling_text_window check failed");

`endif

FILE: rtl/core/stw_pkg.sv
package stw_pkg;

  localparam int CHAR_W  = 21;
  localparam int WW_W    = 7;
  localparam int TICK_W  = 32;
  localparam int TIME_W  = 64;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 5;
  localparam int REGI_W  = 3;

  // configuration register indexes
  typedef enum logic [REGI_W-1:0] {
    REG_WINDOW_WIDTH   = 3'd0,
    REG_TICK_MS        = 3'd1,
    REG_ALWAYS_SCROLL  = 3'd2,
    REG_SCROLL_REVERSE = 3'd3,
    REG_BLANK_CHAR     = 3'd4
  } reg_idx_t;

  // item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // reset values
  localparam logic [WW_W-1:0]   RST_WINDOW_WIDTH = 7'd64;
  localparam logic [TICK_W-1:0] RST_TICK_MS      = 32'd100;
  localparam logic [CHAR_W-1:0] RST_BLANK_CHAR   = 21'd32;

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] char_code;
    logic              first_char;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] column_char;
    logic              last_column;
  } out_item_t;

endpackage

FILE: rtl/core/stw_ram.sv
module stw_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/scrolling_text_window.sv
// Scrolling text window. A load item (func 0) appends one code point to the
// message held in an on-chip RAM, or restarts it at entry zero with
// first_char; busy stays low, so loads may follow each other on every clock
// while no render is in progress. A render item (func 1) raises busy and
// produces one result per window column on consecutive cycles, with
// last_column set on the final one. When the window scrolls, the position
// (time_ms / tick_ms) mod (message length + width), mirrored for reverse
// scrolling, comes from one restoring divider that yields one quotient bit
// per cycle and folds it into the running modulo at once. Busy stays high
// through the divider steps and the step that forms the position (scrolling
// only), the columns, and the read and output stages. The result strobe
// out_valid is high for one cycle per column and the receiver cannot stall it.
module scrolling_text_window
  import stw_pkg::*;
#(
  parameter int MAX_MESSAGE = 4096,
  parameter int MAX_WIDTH   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int LEN_W  = $clog2(MAX_MESSAGE + 1);
  localparam int ADDR_W = $clog2(MAX_MESSAGE);
  localparam int POS_W  = $clog2(MAX_MESSAGE + 2 * MAX_WIDTH);
  localparam int STEP_W = $clog2(TIME_W);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_END, S_COLS} state_t;

  // configuration registers
  logic [WW_W-1:0]   window_width_r;
  logic [TICK_W-1:0] tick_ms_r;
  logic              always_scroll_r;
  logic              scroll_reverse_r;
  logic [CHAR_W-1:0] blank_char_r;

  // message and render state
  logic [LEN_W-1:0]  len_r;
  state_t            state_r;
  logic [TIME_W-1:0] time_r;
  logic [TICK_W-1:0] tick_r;
  logic [TICK_W-1:0] rem_r;
  logic [POS_W-1:0]  mod_r;
  logic [POS_W-1:0]  period_r;
  logic [WW_W-1:0]   w_r;
  logic [STEP_W-1:0] step_r;
  logic [WW_W-1:0]   col_r;
  logic [POS_W-1:0]  pos_r;
  logic              p1_valid_r;
  logic              p1_inmsg_r;
  logic              p1_last_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              accept;
  logic              cfg_wr;
  logic [REGI_W-1:0] cfg_idx;
  logic [WW_W-1:0]   w_eff;
  logic              scroll;
  logic              load_ok;
  logic [LEN_W-1:0]  load_addr;
  logic [TICK_W:0]   rem_sh;
  logic              qbit;
  logic [TICK_W-1:0] rem_nxt;
  logic [POS_W:0]    mod_sh;
  logic [POS_W-1:0]  mod_nxt;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  idx;
  logic              in_msg;
  logic              col_last;
  logic              rd_en;
  logic [CHAR_W-1:0] rd_data;

  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign busy    = (state_r != S_IDLE) || p1_valid_r || out_valid_r;

  // register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_WINDOW_WIDTH:   prdata = CFG_W'(window_width_r);
      REG_TICK_MS:        prdata = CFG_W'(tick_ms_r);
      REG_ALWAYS_SCROLL:  prdata = CFG_W'(always_scroll_r);
      REG_SCROLL_REVERSE: prdata = CFG_W'(scroll_reverse_r);
      REG_BLANK_CHAR:     prdata = CFG_W'(blank_char_r);
      default:            prdata = '0;
    endcase
  end

  // clamp the width into 1..MAX_WIDTH
  always_comb begin
    priority if (window_width_r == '0) begin
      w_eff = WW_W'(1);
    end else if (window_width_r > WW_W'(MAX_WIDTH)) begin
      w_eff = WW_W'(MAX_WIDTH);
    end else begin
      w_eff = window_width_r;
    end
  end

  assign scroll = always_scroll_r || (POS_W'(len_r) > POS_W'(w_eff));

  // load path: append at the end, or restart at entry zero
  assign load_addr = in_item.first_char ? '0 : len_r;
  assign load_ok   = accept && (in_item.func == FUNC_LOAD) &&
                     (in_item.first_char || (len_r < LEN_W'(MAX_MESSAGE)));

  // one quotient bit per cycle, folded into the running modulo
  assign rem_sh  = {rem_r, time_r[TIME_W-1]};
  assign qbit    = rem_sh >= {1'b0, tick_r};
  assign rem_nxt = qbit ? TICK_W'(rem_sh - {1'b0, tick_r}) : rem_sh[TICK_W-1:0];
  assign mod_sh  = {mod_r, qbit};
  assign mod_nxt = (mod_sh >= {1'b0, period_r}) ? POS_W'(mod_sh - {1'b0, period_r})
                                                : mod_sh[POS_W-1:0];

  assign end_pos = scroll_reverse_r ? POS_W'(period_r - mod_r) : mod_r;

  // column address: pos_r is the message index plus the width
  assign idx      = POS_W'(pos_r - POS_W'(w_r));
  assign in_msg   = (pos_r >= POS_W'(w_r)) && (idx < POS_W'(len_r));
  assign col_last = (col_r == WW_W'(w_r - WW_W'(1)));
  assign rd_en    = (state_r == S_COLS) && in_msg;

  stw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_MESSAGE)
  ) u_msg_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_addr[ADDR_W-1:0]),
    .wdata (in_item.char_code),
    .re    (rd_en),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // control, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_width_r   <= RST_WINDOW_WIDTH;
      tick_ms_r        <= RST_TICK_MS;
      always_scroll_r  <= 1'b0;
      scroll_reverse_r <= 1'b0;
      blank_char_r     <= RST_BLANK_CHAR;
      len_r            <= '0;
      state_r          <= S_IDLE;
      p1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_WINDOW_WIDTH:   window_width_r   <= pwdata[WW_W-1:0];
          REG_TICK_MS:        tick_ms_r        <= pwdata[TICK_W-1:0];
          REG_ALWAYS_SCROLL:  always_scroll_r  <= pwdata[0];
          REG_SCROLL_REVERSE: scroll_reverse_r <= pwdata[0];
          REG_BLANK_CHAR:     blank_char_r     <= pwdata[CHAR_W-1:0];
          default: ;
        endcase
      end

      // message length
      if (load_ok) begin
        len_r <= LEN_W'(load_addr + LEN_W'(1));
      end

      // render sequencer
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_item.func == FUNC_RENDER)) begin
            w_r      <= w_eff;
            time_r   <= in_item.time_ms;
            tick_r   <= (tick_ms_r == '0) ? TICK_W'(1) : tick_ms_r;
            period_r <= POS_W'(POS_W'(len_r) + POS_W'(w_eff));
            rem_r    <= '0;
            mod_r    <= '0;
            step_r   <= '0;
            col_r    <= '0;
            if (scroll) begin
              state_r <= S_DIV;
            end else begin
              pos_r   <= POS_W'(w_eff);
              state_r <= S_COLS;
            end
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          mod_r  <= mod_nxt;
          time_r <= {time_r[TIME_W-2:0], 1'b0};
          step_r <= STEP_W'(step_r + STEP_W'(1));
          if (step_r == STEP_W'(TIME_W - 1)) begin
            state_r <= S_END;
          end
        end
        S_END: begin
          pos_r   <= end_pos;
          state_r <= S_COLS;
        end
        S_COLS: begin
          pos_r <= POS_W'(pos_r + POS_W'(1));
          col_r <= WW_W'(col_r + WW_W'(1));
          if (col_last) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // read stage, then output stage
      p1_valid_r  <= (state_r == S_COLS);
      p1_inmsg_r  <= in_msg;
      p1_last_r   <= col_last;
      out_valid_r <= p1_valid_r;
      out_item_r.column_char <= p1_inmsg_r ? rd_data : blank_char_r;
      out_item_r.last_column <= p1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/core/stw_checker.sv
`include "scrolling_text_window_assert.svh"

module stw_checker
  import stw_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input in_item_t           in_item,
  input logic               out_valid,
  input out_item_t          out_item
);

  logic take_load;
  logic take_render;

  assign take_load   = start && !busy && (in_item.func == FUNC_LOAD);
  assign take_render = start && !busy && (in_item.func == FUNC_RENDER);

  // results only come out of a render in progress
  `STW_ASSERT_NOW(a_out_while_busy, out_valid, busy)

  // a load never causes a result
  `STW_ASSERT_NEXT(a_load_silent, take_load, !out_valid)

  // a render holds the block busy
  `STW_ASSERT_NEXT(a_render_busy, take_render, busy)

  // columns of one window come without gaps
  `STW_ASSERT_NEXT(a_cols_contiguous, out_valid && !out_item.last_column, out_valid)

endmodule

bind scrolling_text_window stw_checker u_stw_checker (.*);
